// ----- hdl/sss_pkg.sv -----
// Shared types and constants for the servo sweep scan sequencer.
package sss_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_MIN_ANGLE   = 2'd0;
  localparam logic [1:0] CFG_MAX_ANGLE   = 2'd1;
  localparam logic [1:0] CFG_STEP_SIZE   = 2'd2;
  localparam logic [1:0] CFG_SETTLE_TIME = 2'd3;

  // Register reset values
  localparam logic [7:0]  MIN_ANGLE_RST   = 8'd0;
  localparam logic [7:0]  MAX_ANGLE_RST   = 8'd180;
  localparam logic [7:0]  STEP_SIZE_RST   = 8'd5;
  localparam logic [31:0] SETTLE_TIME_RST = 32'd150000;

  // Largest reportable distance
  localparam logic [15:0] DIST_MAX = 16'hFFFF;

  // One tick word from the timer and range sensor
  typedef struct packed {
    logic [31:0] timer_now;
    logic        data_ready;
    logic [31:0] distance;
    logic        sensor_busy;
  } in_word_t;

  // One result word toward servo, sensor and report sink
  typedef struct packed {
    logic        servo_set;
    logic [7:0]  servo_angle;
    logic        start_measure;
    logic        report_valid;
    logic [7:0]  report_angle;
    logic [15:0] report_distance;
  } out_word_t;

  // Sweep position and limits handed to the angle stepper
  typedef struct packed {
    logic [7:0] angle;
    logic       down;
    logic [7:0] min_angle;
    logic [7:0] max_angle;
    logic [7:0] step_size;
  } adv_in_t;

  // Updated sweep position
  typedef struct packed {
    logic [7:0] angle;
    logic       down;
  } adv_out_t;

endpackage

// ----- hdl/servo_sweep_scan_sequencer.sv -----
// Top level of the servo sweep scan sequencer: registers, phase sequencer, handshakes.
//
//  channel | dir | handshake           | word
//  --------+-----+---------------------+---------------------------
//  in      | in  | in_valid/in_ready   | in_data  (sss_pkg::in_word_t)
//  out     | out | out_valid/out_ready | out_data (sss_pkg::out_word_t)
//  cfg     | in  | cfg_we              | cfg_index, cfg_data
//
// One word per cycle while the output is not stalled; an accepted word waits in the input register.
// The input register feeds one pass of phase and angle logic into the output register.
// A stalled output holds the result and the input register; in_ready drops only then.
// Synchronous reset: move phase, angle zero, sweeping up, registers at their defaults.
module servo_sweep_scan_sequencer (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  sss_pkg::in_word_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output sss_pkg::out_word_t out_data,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data
);
  import sss_pkg::*;

  typedef enum logic [1:0] {
    PH_MOVE   = 2'd0,
    PH_SETTLE = 2'd1,
    PH_WAIT   = 2'd2
  } phase_t;

  // Configuration
  logic [7:0]  min_angle;
  logic [7:0]  max_angle;
  logic [7:0]  step_size;
  logic [31:0] settle_time;

  // Sequencer state
  phase_t      phase;
  phase_t      phase_next;
  logic [7:0]  sweep_angle;
  logic [7:0]  sweep_angle_next;
  logic        sweep_down;
  logic        sweep_down_next;
  logic [31:0] move_stamp;
  logic [31:0] move_stamp_next;

  // Input register
  in_word_t    in_q;
  logic        in_full;

  // Step logic
  out_word_t   result;
  logic        advance;
  logic [31:0] elapsed;
  adv_in_t     adv_in;
  adv_out_t    adv_out;

  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;
  assign elapsed  = in_q.timer_now - move_stamp;

  assign adv_in.angle     = sweep_angle;
  assign adv_in.down      = sweep_down;
  assign adv_in.min_angle = min_angle;
  assign adv_in.max_angle = max_angle;
  assign adv_in.step_size = step_size;

  sss_advance u_advance (
    .adv_in  (adv_in),
    .adv_out (adv_out)
  );

  // Phase step for the word in the input register
  always_comb begin
    result             = '0;
    result.servo_angle = sweep_angle;
    phase_next         = phase;
    sweep_angle_next   = sweep_angle;
    sweep_down_next    = sweep_down;
    move_stamp_next    = move_stamp;
    case (phase)
      PH_SETTLE: begin
        if (elapsed >= settle_time) begin
          result.start_measure = 1'b1;
          phase_next           = PH_WAIT;
        end
      end
      PH_WAIT: begin
        // ready wins over busy; idle without data is a timeout
        if (in_q.data_ready) begin
          result.report_valid    = 1'b1;
          result.report_angle    = sweep_angle;
          result.report_distance = (|in_q.distance[31:16]) ? DIST_MAX
                                                            : in_q.distance[15:0];
        end
        if (in_q.data_ready || !in_q.sensor_busy) begin
          sweep_angle_next = adv_out.angle;
          sweep_down_next  = adv_out.down;
          phase_next       = PH_MOVE;
        end
      end
      default: begin
        result.servo_set = 1'b1;
        move_stamp_next  = in_q.timer_now;
        phase_next       = PH_SETTLE;
      end
    endcase
  end

  // State, registers and handshakes
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full     <= 1'b0;
      out_valid   <= 1'b0;
      phase       <= PH_MOVE;
      sweep_angle <= 8'd0;
      sweep_down  <= 1'b0;
      move_stamp  <= 32'd0;
      min_angle   <= MIN_ANGLE_RST;
      max_angle   <= MAX_ANGLE_RST;
      step_size   <= STEP_SIZE_RST;
      settle_time <= SETTLE_TIME_RST;
    end else begin
      if (in_ready) begin
        in_full <= in_valid;
      end
      if (advance) begin
        out_valid   <= 1'b1;
        phase       <= phase_next;
        sweep_angle <= sweep_angle_next;
        sweep_down  <= sweep_down_next;
        move_stamp  <= move_stamp_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_MIN_ANGLE:   min_angle   <= cfg_data[7:0];
          CFG_MAX_ANGLE:   max_angle   <= cfg_data[7:0];
          CFG_STEP_SIZE:   step_size   <= cfg_data[7:0];
          CFG_SETTLE_TIME: settle_time <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q <= in_data;
    end
    if (advance) begin
      out_data <= result;
    end
  end

`ifndef ASSERT_OFF
  a_one_action: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot0({out_data.servo_set, out_data.start_measure,
                            out_data.report_valid}))
    else $error("more than one action in a result word");

  a_move_to_settle: assert property (@(posedge clk) disable iff (rst)
    (advance && phase == PH_MOVE) |=> (phase == PH_SETTLE))
    else $error("move phase did not enter settle phase");

  a_quiet_report: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.report_valid) |->
      (out_data.report_angle == 8'd0 && out_data.report_distance == 16'd0))
    else $error("report fields set without a report");

  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (in_full && out_valid && !out_ready))
    else $error("input stalled without an output stall");
`endif

endmodule

// ----- hdl/sss_advance.sv -----
// Sweep angle stepper: add or subtract the step, bounce at the limits.
module sss_advance (
  input  sss_pkg::adv_in_t  adv_in,
  output sss_pkg::adv_out_t adv_out
);
  import sss_pkg::*;

  logic signed [9:0] angle_s;
  logic signed [9:0] step_s;
  logic signed [9:0] sum;

  assign angle_s = $signed({2'b00, adv_in.angle});
  assign step_s  = $signed({2'b00, adv_in.step_size});
  assign sum     = adv_in.down ? (angle_s - step_s) : (angle_s + step_s);

  // Upper limit is checked first, so it wins when the limits cross
  always_comb begin
    adv_out.angle = sum[7:0];
    adv_out.down  = adv_in.down;
    if (sum >= $signed({2'b00, adv_in.max_angle})) begin
      adv_out.angle = adv_in.max_angle;
      adv_out.down  = 1'b1;
    end else if (sum <= $signed({2'b00, adv_in.min_angle})) begin
      adv_out.angle = adv_in.min_angle;
      adv_out.down  = 1'b0;
    end
  end

endmodule
